// ===== design/gvr_pkg.sv =====
// shared constants and types of the givens rotation coefficient pipeline
package gvr_pkg;

  // default element width
  localparam int DEF_DATA_WIDTH = 16;

  // per-pair flags carried alongside the arithmetic
  typedef struct packed {
    logic neg_a;
    logic neg_b;
    logic zero;
  } pair_flags_t;

endpackage

// ===== design/givens_rotation_coefficients.sv =====
// givens rotation coefficients: norm, cosine and sine of an element pair
//
//   channel | dir | payload                               | accepted when
//   in_     | in  | tdata: elem_a, elem_b                 | in_tvalid & in_tready
//   out_    | out | tdata: norm_r, cos_val, sin_val; user | out_tvalid & out_tready
//
// one pair per cycle while the skid entry is empty; the depth is set by the square root
// and divider pipelines at one result bit per stage
// reset clears valid bits only; payload registers are not reset
// an output register plus one skid entry separate the pipeline from out_tready;
// in_tready drops only while the skid entry is occupied, and the whole pipeline
// holds in place then
module givens_rotation_coefficients #(
  parameter int DATA_WIDTH = gvr_pkg::DEF_DATA_WIDTH,
  localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // elem_a, elem_b
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // norm_r, cos_val, sin_val
  output logic                   out_tuser   // zero_pair
);
  import gvr_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int FLAGS_W = $bits(pair_flags_t);
  localparam logic [W-1:0] ONE_Q = W'(1) << (W - 1);

  logic en;

  // stage 1: magnitudes and signs
  logic              s1_vld_r;
  logic [W-1:0]      s1_mag_a_r, s1_mag_b_r;
  pair_flags_t       s1_flags_r;
  logic [W-1:0]      elem_a, elem_b;
  logic [W-1:0]      mag_a_nxt, mag_b_nxt;
  pair_flags_t       flags_nxt;

  // stage 2: squares
  logic              s2_vld_r;
  logic [2*W-1:0]    s2_sq_a_r, s2_sq_b_r;
  logic [W-1:0]      s2_mag_a_r, s2_mag_b_r;
  pair_flags_t       s2_flags_r;

  // stage 3: sum of squares
  logic              s3_vld_r;
  logic [2*W-1:0]    s3_sum_r;
  logic [W-1:0]      s3_mag_a_r, s3_mag_b_r;
  pair_flags_t       s3_flags_r;

  // square root outputs
  logic                      sq_vld;
  logic [W-1:0]              sq_root;
  logic [W:0]                sq_rem;
  logic [2*W+FLAGS_W-1:0]    sq_side;
  logic [W-1:0]              sq_mag_a, sq_mag_b;
  pair_flags_t               sq_flags;

  // stage 4: rounded norm and scaled numerators
  logic              s4_vld_r;
  logic [W-1:0]      s4_norm_r;
  logic [2*W-1:0]    s4_num_a_r, s4_num_b_r;
  pair_flags_t       s4_flags_r;
  logic [W-1:0]      norm_nxt;

  // divider outputs
  logic                  dv_vld;
  logic [W-1:0]          dv_quo_a, dv_quo_b;
  logic [W+FLAGS_W-1:0]  dv_side;
  logic [W-1:0]          dv_norm;
  pair_flags_t           dv_flags;

  // stage 5: saturated coefficients
  logic              s5_vld_r;
  logic [W-1:0]      s5_norm_r, s5_cos_r, s5_sin_r;
  logic              s5_zero_r;

  // output register and skid entry
  logic              out_vld_r;
  logic [W-1:0]      out_norm_r, out_cos_r, out_sin_r;
  logic              out_zero_r;
  logic              skid_full_r;
  logic [W-1:0]      skid_norm_r, skid_cos_r, skid_sin_r;
  logic              skid_zero_r;

  // saturated signed quotient from its magnitude
  function automatic logic [W-1:0] sat_q(input logic [W-1:0] q, input logic neg);
    logic [W-1:0] m;
    if (neg) begin
      m = (q > ONE_Q) ? ONE_Q : q;
      return W'(~m + W'(1));
    end
    return (q > ONE_Q - W'(1)) ? ONE_Q - W'(1) : q;
  endfunction

  // the pipeline advances unless a result is parked in the skid entry
  assign en        = !skid_full_r;
  assign in_tready = en;

  // stage 1
  always_comb begin
    elem_a          = in_tdata[W-1:0];
    elem_b          = in_tdata[2*W-1:W];
    flags_nxt.neg_a = elem_a[W-1];
    flags_nxt.neg_b = elem_b[W-1];
    flags_nxt.zero  = (elem_a == '0) && (elem_b == '0);
    mag_a_nxt       = elem_a[W-1] ? W'(~elem_a + W'(1)) : elem_a;
    mag_b_nxt       = elem_b[W-1] ? W'(~elem_b + W'(1)) : elem_b;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= sq_vld;
      s5_vld_r <= dv_vld;
    end
  end

  // stages 1 to 3: magnitudes, squares, sum
  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_a_r <= mag_a_nxt;
      s1_mag_b_r <= mag_b_nxt;
      s1_flags_r <= flags_nxt;
      s2_sq_a_r  <= (2*W)'(s1_mag_a_r) * (2*W)'(s1_mag_a_r);
      s2_sq_b_r  <= (2*W)'(s1_mag_b_r) * (2*W)'(s1_mag_b_r);
      s2_mag_a_r <= s1_mag_a_r;
      s2_mag_b_r <= s1_mag_b_r;
      s2_flags_r <= s1_flags_r;
      s3_sum_r   <= s2_sq_a_r + s2_sq_b_r;
      s3_mag_a_r <= s2_mag_a_r;
      s3_mag_b_r <= s2_mag_b_r;
      s3_flags_r <= s2_flags_r;
    end
  end

  gvr_sqrt_pipe #(
    .W      (W),
    .SIDE_W (2 * W + FLAGS_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_rad    (s3_sum_r),
    .in_side   ({s3_mag_a_r, s3_mag_b_r, s3_flags_r}),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_rem   (sq_rem),
    .out_side  (sq_side)
  );

  assign {sq_mag_a, sq_mag_b, sq_flags} = sq_side;

  // stage 4: round the root up when the remainder exceeds it
  assign norm_nxt = (sq_rem > {1'b0, sq_root}) ? sq_root + W'(1) : sq_root;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_norm_r  <= norm_nxt;
      s4_num_a_r <= {1'b0, sq_mag_a, {(W-1){1'b0}}} + {{(W+1){1'b0}}, norm_nxt[W-1:1]};
      s4_num_b_r <= {1'b0, sq_mag_b, {(W-1){1'b0}}} + {{(W+1){1'b0}}, norm_nxt[W-1:1]};
      s4_flags_r <= sq_flags;
    end
  end

  gvr_div_pipe #(
    .W      (W),
    .SIDE_W (W + FLAGS_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_vld_r),
    .in_num_a  (s4_num_a_r),
    .in_num_b  (s4_num_b_r),
    .in_den    (s4_norm_r),
    .in_side   ({s4_norm_r, s4_flags_r}),
    .out_valid (dv_vld),
    .out_quo_a (dv_quo_a),
    .out_quo_b (dv_quo_b),
    .out_side  (dv_side)
  );

  assign {dv_norm, dv_flags} = dv_side;

  // stage 5: sign, saturation and the identity rotation for a zero pair
  always_ff @(posedge clk) begin
    if (en) begin
      s5_zero_r <= dv_flags.zero;
      if (dv_flags.zero) begin
        s5_norm_r <= '0;
        s5_cos_r  <= ONE_Q - W'(1);
        s5_sin_r  <= '0;
      end else begin
        s5_norm_r <= dv_norm;
        s5_cos_r  <= sat_q(dv_quo_a, dv_flags.neg_a);
        s5_sin_r  <= sat_q(dv_quo_b, dv_flags.neg_b);
      end
    end
  end

  // output valid and skid occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_tready) begin
        skid_full_r <= 1'b0;
      end
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= s5_vld_r;
    end else if (s5_vld_r) begin
      skid_full_r <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_tready) begin
        out_norm_r <= skid_norm_r;
        out_cos_r  <= skid_cos_r;
        out_sin_r  <= skid_sin_r;
        out_zero_r <= skid_zero_r;
      end
    end else if (!out_vld_r || out_tready) begin
      out_norm_r <= s5_norm_r;
      out_cos_r  <= s5_cos_r;
      out_sin_r  <= s5_sin_r;
      out_zero_r <= s5_zero_r;
    end else begin
      skid_norm_r <= s5_norm_r;
      skid_cos_r  <= s5_cos_r;
      skid_sin_r  <= s5_sin_r;
      skid_zero_r <= s5_zero_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'({out_sin_r, out_cos_r, out_norm_r});
  assign out_tuser  = out_zero_r;

  // a parked result always sits behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_vld_r)
    else $error("skid entry occupied with no output pending");

  // a result leaving the pipeline into a stalled output is parked, not dropped
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_full_r && out_vld_r && !out_tready && s5_vld_r) |=> skid_full_r)
    else $error("pipeline result lost at a stalled output");

  // the skid entry fills only on a stalled output transfer
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid entry filled without a stall");

  // a zero pair gives zero norm and sine; any other pair a nonzero norm
  a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser ? (out_norm_r == '0 && out_sin_r == '0)
                              : (out_norm_r != '0)))
    else $error("norm inconsistent with zero pair flag");

endmodule

// ===== design/gvr_sqrt_pipe.sv =====
// pipelined integer square root, one root bit per stage, with sideband
module gvr_sqrt_pipe #(
  parameter int W      = gvr_pkg::DEF_DATA_WIDTH,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*W-1:0]    in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W-1:0]      out_root,
  output logic [W:0]        out_rem,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [W];
  logic [W-1:0]      root_r [W];
  logic [W:0]        rem_r  [W];
  logic [2*W-1:0]    rad_r  [W];
  logic [SIDE_W-1:0] side_r [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic              src_v;
    logic [W-1:0]      src_root;
    logic [W:0]        src_rem;
    logic [2*W-1:0]    src_rad;
    logic [SIDE_W-1:0] src_side;
    logic [W+1:0]      shifted;
    logic [W+1:0]      trial;
    logic [W+1:0]      diff;
    logic              ge;
    logic [W-1:0]      root_nxt;
    logic [W:0]        rem_nxt;

    // stage source: the inputs for the first stage, the previous stage otherwise
    if (k == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_root = '0;
      assign src_rem  = '0;
      assign src_rad  = in_rad;
      assign src_side = in_side;
    end else begin : g_next
      assign src_v    = vld_r[k-1];
      assign src_root = root_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_rad  = rad_r[k-1];
      assign src_side = side_r[k-1];
    end

    // bring down two radicand bits and try root*4+1
    always_comb begin
      shifted  = {src_rem[W-1:0], src_rad[2*W-1 -: 2]};
      trial    = {src_root, 2'b01};
      diff     = shifted - trial;
      ge       = (shifted >= trial);
      rem_nxt  = ge ? diff[W:0] : shifted[W:0];
      root_nxt = {src_root[W-2:0], ge};
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_v;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= root_nxt;
        rem_r[k]  <= rem_nxt;
        rad_r[k]  <= {src_rad[2*W-3:0], 2'b00};
        side_r[k] <= src_side;
      end
    end
  end

  assign out_valid = vld_r[W-1];
  assign out_root  = root_r[W-1];
  assign out_rem   = rem_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

// ===== design/gvr_div_pipe.sv =====
// pipelined restoring divider, two numerators over one divisor, one quotient bit per stage
module gvr_div_pipe #(
  parameter int W      = gvr_pkg::DEF_DATA_WIDTH,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*W-1:0]    in_num_a,
  input  logic [2*W-1:0]    in_num_b,
  input  logic [W-1:0]      in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W-1:0]      out_quo_a,
  output logic [W-1:0]      out_quo_b,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r   [W];
  logic [W-1:0]      den_r   [W];
  logic [W-1:0]      rem_a_r [W];
  logic [W-1:0]      low_a_r [W];
  logic [W-1:0]      quo_a_r [W];
  logic [W-1:0]      rem_b_r [W];
  logic [W-1:0]      low_b_r [W];
  logic [W-1:0]      quo_b_r [W];
  logic [SIDE_W-1:0] side_r  [W];

  // one restoring step: returns {new remainder, quotient bit}
  function automatic logic [W:0] div_step(input logic [W-1:0] rem, input logic nbit,
                                          input logic [W-1:0] den);
    logic [W:0] t;
    logic [W:0] d;
    logic       ge;
    t  = {rem, nbit};
    d  = t - {1'b0, den};
    ge = (t >= {1'b0, den});
    return ge ? {d[W-1:0], 1'b1} : {t[W-1:0], 1'b0};
  endfunction

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic              src_v;
    logic [W-1:0]      src_den;
    logic [W-1:0]      src_rem_a;
    logic [W-1:0]      src_low_a;
    logic [W-1:0]      src_quo_a;
    logic [W-1:0]      src_rem_b;
    logic [W-1:0]      src_low_b;
    logic [W-1:0]      src_quo_b;
    logic [SIDE_W-1:0] src_side;
    logic [W:0]        step_a;
    logic [W:0]        step_b;

    // stage source: split numerators at entry, previous stage otherwise
    if (k == 0) begin : g_first
      assign src_v     = in_valid;
      assign src_den   = in_den;
      assign src_rem_a = in_num_a[2*W-1:W];
      assign src_low_a = in_num_a[W-1:0];
      assign src_quo_a = '0;
      assign src_rem_b = in_num_b[2*W-1:W];
      assign src_low_b = in_num_b[W-1:0];
      assign src_quo_b = '0;
      assign src_side  = in_side;
    end else begin : g_next
      assign src_v     = vld_r[k-1];
      assign src_den   = den_r[k-1];
      assign src_rem_a = rem_a_r[k-1];
      assign src_low_a = low_a_r[k-1];
      assign src_quo_a = quo_a_r[k-1];
      assign src_rem_b = rem_b_r[k-1];
      assign src_low_b = low_b_r[k-1];
      assign src_quo_b = quo_b_r[k-1];
      assign src_side  = side_r[k-1];
    end

    // both lanes share the divisor
    assign step_a = div_step(src_rem_a, src_low_a[W-1], src_den);
    assign step_b = div_step(src_rem_b, src_low_b[W-1], src_den);

    // stage valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_v;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]   <= src_den;
        rem_a_r[k] <= step_a[W:1];
        low_a_r[k] <= {src_low_a[W-2:0], 1'b0};
        quo_a_r[k] <= {src_quo_a[W-2:0], step_a[0]};
        rem_b_r[k] <= step_b[W:1];
        low_b_r[k] <= {src_low_b[W-2:0], 1'b0};
        quo_b_r[k] <= {src_quo_b[W-2:0], step_b[0]};
        side_r[k]  <= src_side;
      end
    end
  end

  assign out_valid = vld_r[W-1];
  assign out_quo_a = quo_a_r[W-1];
  assign out_quo_b = quo_b_r[W-1];
  assign out_side  = side_r[W-1];

endmodule
